// File: hw/rtl/rims_pkg.sv
// ============================================================================
// rims_pkg
// Shared widths, limits and types for the rotation-invariant minimum SSD block.
// ============================================================================
`default_nettype none

package rims_pkg;

    // descriptor element and arithmetic widths
    localparam int FEAT_W  = 9;
    localparam int DIFF_W  = FEAT_W + 1;
    localparam int SQ_W    = 18;
    localparam int SQ_MAX  = 260100;
    localparam int SSD_W   = 22;
    localparam logic [SSD_W-1:0] SSD_MAX = {SSD_W{1'b1}};

    // shift bound register
    localparam int SHIFT_W = 4;
    localparam int SHIFT_LIMIT = (1 << SHIFT_W) - 1;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd1;

    // default descriptor length
    localparam int VECTOR_LENGTH_DEF = 16;

    // register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_MAX_SHIFT = 1'b0;

    // control from sequencer to every cell
    typedef struct packed {
        logic clear;
        logic add_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/rims_cell.sv
// ============================================================================
// rims_cell
// One shift cell: holds a reference sample passed along the chain, squares
// its difference to the broadcast query sample, accumulates the SSD of its
// own shift and takes part in the min wave that runs down the chain.
// ============================================================================
`default_nettype none

module rims_cell #(
    parameter int ACC_W = 22,
    parameter int DIST  = 0
) (
    input  wire logic                               clk,
    input  wire rims_pkg::cell_ctrl_t               ctrl,
    input  wire logic [rims_pkg::SHIFT_W-1:0]       shift_bound,
    input  wire logic signed [rims_pkg::FEAT_W-1:0] query_bcast,
    input  wire logic signed [rims_pkg::FEAT_W-1:0] ref_in,
    output logic signed [rims_pkg::FEAT_W-1:0]      ref_out,
    input  wire logic [ACC_W-1:0]                   min_in,
    output logic [ACC_W-1:0]                        min_out
);

    logic signed [rims_pkg::FEAT_W-1:0]   ref_reg;
    logic [rims_pkg::SQ_W-1:0]            sq_reg;
    logic [ACC_W-1:0]                     acc_reg;
    logic [ACC_W-1:0]                     min_reg;

    logic signed [rims_pkg::DIFF_W-1:0]   diff;
    logic signed [2*rims_pkg::DIFF_W-1:0] prod;
    logic [rims_pkg::SQ_W-1:0]            sq_next;
    logic [ACC_W-1:0]                     acc_next;
    logic [ACC_W-1:0]                     min_next;
    logic                                 in_set;

    always_comb
    begin
        diff    = {query_bcast[rims_pkg::FEAT_W-1], query_bcast}
                - {ref_reg[rims_pkg::FEAT_W-1], ref_reg};
        prod    = diff * diff;
        sq_next = prod[rims_pkg::SQ_W-1:0];

        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.add_en)
        begin
            acc_next = acc_reg + ACC_W'(sq_reg);
        end
        else
        begin
            acc_next = acc_reg;
        end

        // only shifts within the bound take part in the minimum
        in_set = (shift_bound >= rims_pkg::SHIFT_W'(DIST));
        if (in_set && (acc_reg < min_in))
        begin
            min_next = acc_reg;
        end
        else
        begin
            min_next = min_in;
        end
    end

    always_ff @(posedge clk)
    begin
        ref_reg <= ref_in;
        sq_reg  <= sq_next;
        acc_reg <= acc_next;
        min_reg <= min_next;
    end

    assign ref_out = ref_reg;
    assign min_out = min_reg;

endmodule

`default_nettype wire

// File: hw/rtl/rotation_invariant_min_ssd.sv
// ============================================================================
// rotation_invariant_min_ssd
// Loads a query and a reference descriptor one element pair per item, then
// finds the smallest sum of squared differences over all circular shifts
// within the programmed bound, using a chain of shift cells.
// ============================================================================
// Operation: each loading item stores one element pair; the item with the last flag
// starts a pass that ends in out_valid (L pairs held, M = min(15, VECTOR_LENGTH/2)
// cells each way): the reference stream fills the chain, the cells accumulate
// over the L pairs, then the min wave runs down the chain.
// No item is taken during the pass or until the result is loaded for output.
// Reset clears control, load count and max_shift (to 1).
`default_nettype none

module rotation_invariant_min_ssd #(
    parameter int VECTOR_LENGTH = rims_pkg::VECTOR_LENGTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [rims_pkg::FEAT_W-1:0]   query_feature,
    input  wire logic signed [rims_pkg::FEAT_W-1:0]   reference_feature,
    input  wire logic                                 last_element,

    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [rims_pkg::SSD_W-1:0]                min_ssd,

    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [rims_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [rims_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rims_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                      pready
);

    localparam int IDX_W = $clog2(VECTOR_LENGTH);
    localparam int CNT_W = $clog2(VECTOR_LENGTH + 1);
    localparam int ACC_W = $clog2(VECTOR_LENGTH * rims_pkg::SQ_MAX + 1);
    localparam int CMP_W = (ACC_W > rims_pkg::SSD_W) ? ACC_W : rims_pkg::SSD_W;
    localparam int SB_W  = (CNT_W > rims_pkg::SHIFT_W) ? CNT_W : rims_pkg::SHIFT_W;
    localparam int MAX_SHIFT = (rims_pkg::SHIFT_LIMIT < VECTOR_LENGTH / 2)
                             ? rims_pkg::SHIFT_LIMIT : VECTOR_LENGTH / 2;
    localparam int NUM_CELLS = 2 * MAX_SHIFT + 1;
    localparam int T_W   = $clog2(4 * MAX_SHIFT + VECTOR_LENGTH + 6);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // element stores
    logic signed [rims_pkg::FEAT_W-1:0] query_mem [VECTOR_LENGTH];
    logic signed [rims_pkg::FEAT_W-1:0] ref_mem   [VECTOR_LENGTH];

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              load_cnt_reg, load_cnt_next;
    logic [rims_pkg::SHIFT_W-1:0]  max_shift_reg, max_shift_next;
    logic [T_W-1:0]                t_reg, t_next;
    logic [IDX_W-1:0]              rp_reg, rp_next;
    logic [IDX_W-1:0]              qp_reg, qp_next;
    logic [CNT_W-1:0]              len_reg, len_next;
    logic [rims_pkg::SHIFT_W-1:0]  bound_reg, bound_next;
    logic                          clear_reg, clear_next;
    logic                          add_en_reg, add_en_next;
    logic                          out_valid_reg, out_valid_next;

    logic [rims_pkg::SSD_W-1:0]          min_ssd_reg;
    logic signed [rims_pkg::FEAT_W-1:0]  qb_reg;
    logic signed [rims_pkg::FEAT_W-1:0]  ref_rd_reg;

    logic                          in_accept;
    logic                          cfg_write;
    logic                          room;
    logic [CNT_W-1:0]              len_load;
    logic [CNT_W-1:0]              half_len;
    logic                          mul_ok;
    logic                          pass_done;
    logic                          out_load;
    logic [rims_pkg::SSD_W-1:0]    result_sat;
    logic [CMP_W-1:0]              min_wide;

    rims_pkg::cell_ctrl_t          cell_ctrl;

    logic signed [rims_pkg::FEAT_W-1:0] ref_chain [NUM_CELLS];
    logic [ACC_W-1:0]                   min_chain [NUM_CELLS+1];

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == rims_pkg::REG_MAX_SHIFT);
    assign room      = (load_cnt_reg < CNT_W'(VECTOR_LENGTH));
    assign len_load  = room ? (load_cnt_reg + CNT_W'(1)) : load_cnt_reg;
    assign half_len  = len_load >> 1;

    assign mul_ok    = (t_reg >= T_W'(2 * MAX_SHIFT + 2))
                    && (t_reg <= (T_W'(2 * MAX_SHIFT + 1) + T_W'(len_reg)));
    assign pass_done = (t_reg == (T_W'(4 * MAX_SHIFT + 4) + T_W'(len_reg)));
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign min_wide   = CMP_W'(min_chain[NUM_CELLS]);
    assign result_sat = (min_wide > CMP_W'(rims_pkg::SSD_MAX))
                      ? rims_pkg::SSD_MAX : min_wide[rims_pkg::SSD_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        max_shift_next = max_shift_reg;
        t_next         = t_reg;
        rp_next        = rp_reg;
        qp_next        = qp_reg;
        len_next       = len_reg;
        bound_next     = bound_reg;
        clear_next     = 1'b0;
        add_en_next    = 1'b0;
        out_valid_next = out_valid_reg;

        if (cfg_write)
        begin
            max_shift_next = pwdata[rims_pkg::SHIFT_W-1:0];
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (last_element)
                    begin
                        // latch length and shift bound, start the pass
                        len_next = len_load;
                        if (SB_W'(max_shift_reg) > SB_W'(half_len))
                        begin
                            bound_next = rims_pkg::SHIFT_W'(half_len);
                        end
                        else
                        begin
                            bound_next = max_shift_reg;
                        end
                        load_cnt_next = '0;
                        t_next        = '0;
                        rp_next       = '0;
                        qp_next       = '0;
                        clear_next    = 1'b1;
                        state_next    = ST_RUN;
                    end
                    else
                    begin
                        load_cnt_next = len_load;
                    end
                end
            end
            ST_RUN:
            begin
                t_next      = t_reg + T_W'(1);
                add_en_next = mul_ok;
                // walk both stores circularly; the query pointer holds until t_reg reaches MAX_SHIFT + 1
                if (CNT_W'(rp_reg) == (len_reg - CNT_W'(1)))
                begin
                    rp_next = '0;
                end
                else
                begin
                    rp_next = rp_reg + IDX_W'(1);
                end
                if (t_reg >= T_W'(MAX_SHIFT + 1))
                begin
                    if (CNT_W'(qp_reg) == (len_reg - CNT_W'(1)))
                    begin
                        qp_next = '0;
                    end
                    else
                    begin
                        qp_next = qp_reg + IDX_W'(1);
                    end
                end
                if (pass_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            load_cnt_reg  <= '0;
            max_shift_reg <= rims_pkg::SHIFT_RESET;
            t_reg         <= '0;
            rp_reg        <= '0;
            qp_reg        <= '0;
            len_reg       <= '0;
            bound_reg     <= '0;
            clear_reg     <= 1'b0;
            add_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            max_shift_reg <= max_shift_next;
            t_reg         <= t_next;
            rp_reg        <= rp_next;
            qp_reg        <= qp_next;
            len_reg       <= len_next;
            bound_reg     <= bound_next;
            clear_reg     <= clear_next;
            add_en_reg    <= add_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stores and datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept && room)
        begin
            query_mem[load_cnt_reg[IDX_W-1:0]] <= query_feature;
            ref_mem[load_cnt_reg[IDX_W-1:0]]   <= reference_feature;
        end
        qb_reg     <= query_mem[qp_reg];
        ref_rd_reg <= ref_mem[rp_reg];
        if (out_load)
        begin
            min_ssd_reg <= result_sat;
        end
    end

    assign cell_ctrl.clear  = clear_reg;
    assign cell_ctrl.add_en = add_en_reg;

    assign ref_chain[0] = ref_rd_reg;
    assign min_chain[0] = '1;

    // cell c handles circular shift MAX_SHIFT - c
    for (genvar c = 0; c < NUM_CELLS; c++)
    begin : g_cell
        localparam int DIST = (c >= MAX_SHIFT) ? (c - MAX_SHIFT) : (MAX_SHIFT - c);
        if (c < NUM_CELLS - 1)
        begin : g_mid
            rims_cell #(
                .ACC_W (ACC_W),
                .DIST  (DIST)
            ) u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl),
                .shift_bound (bound_reg),
                .query_bcast (qb_reg),
                .ref_in      (ref_chain[c]),
                .ref_out     (ref_chain[c+1]),
                .min_in      (min_chain[c]),
                .min_out     (min_chain[c+1])
            );
        end
        else
        begin : g_end
            rims_cell #(
                .ACC_W (ACC_W),
                .DIST  (DIST)
            ) u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl),
                .shift_bound (bound_reg),
                .query_bcast (qb_reg),
                .ref_in      (ref_chain[c]),
                .ref_out     (),
                .min_in      (min_chain[c]),
                .min_out     (min_chain[c+1])
            );
        end
    end

    assign out_valid = out_valid_reg;
    assign min_ssd   = min_ssd_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rims_pkg::REG_MAX_SHIFT)
                  ? rims_pkg::APB_DATA_W'(max_shift_reg) : '0;

endmodule

`default_nettype wire
